### design/i2cbm_pkg.sv
// Package for the I2C bit-level master: command codes, queue word type,
// line-level type and the per-phase decode functions. No dependencies.
package i2cbm_pkg;

    typedef enum logic [2:0] {
        OP_TICK  = 3'd0,
        OP_START = 3'd1,
        OP_STOP  = 3'd2,
        OP_WRITE = 3'd3,
        OP_READ  = 3'd4,
        OP_ACK   = 3'd5,
        OP_NACK  = 3'd6,
        OP_RACK  = 3'd7
    } t_op;

    localparam int unsigned BYTE_PHASES = 17;
    localparam int unsigned IN_WIDTH    = 16;
    localparam int unsigned OUT_WIDTH   = 16;

    // word handed from the front to the engine
    typedef struct packed {
        logic       is_cmd;
        t_op        op;
        logic [7:0] data;
        logic       sda;
    } t_item;

    typedef struct packed {
        logic scl;
        logic sda;
        logic drv;
    } t_lines;

    function automatic logic [4:0] f_phase_count(input t_op op);
        logic [4:0] n;
        case (op)
            OP_START: n = 5'd4;
            OP_STOP:  n = 5'd3;
            OP_WRITE: n = 5'(BYTE_PHASES);
            OP_READ:  n = 5'(BYTE_PHASES);
            OP_ACK:   n = 5'd3;
            OP_NACK:  n = 5'd3;
            OP_RACK:  n = 5'd3;
            default:  n = 5'd0;
        endcase
        return n;
    endfunction

    // line levels on entry to phase p; sr7 is the shift register MSB
    function automatic t_lines f_enter(input t_op op, input logic [4:0] p,
                                       input logic sr7, input t_lines cur);
        t_lines r;
        r = cur;
        case (op)
            OP_START: begin
                r.scl = (p[1:0] == 2'd1) || (p[1:0] == 2'd2);
                r.sda = !p[1];
                r.drv = 1'b1;
            end
            OP_STOP: begin
                r.scl = (p != 5'd0);
                r.sda = (p >= 5'd2);
                r.drv = 1'b1;
            end
            OP_WRITE: begin
                if (p < 5'd16) begin
                    r.scl = p[0];
                    r.sda = sr7;
                end else begin
                    r.scl = 1'b0;
                end
                r.drv = 1'b1;
            end
            OP_READ: begin
                r.scl = (p < 5'd16) ? p[0] : 1'b0;
                r.sda = 1'b1;
                r.drv = 1'b0;
            end
            OP_ACK, OP_NACK: begin
                r.scl = (p == 5'd1);
                r.sda = (op == OP_NACK);
                r.drv = 1'b1;
            end
            OP_RACK: begin
                r.scl = (p == 5'd1);
                r.sda = 1'b1;
                r.drv = 1'b0;
            end
            default: r = cur;
        endcase
        return r;
    endfunction

endpackage

### design/i2cbm_front.sv
// Front end of the I2C bit-level master: accepts stream words, classifies
// them as tick or command and holds them in a two-word queue. Uses i2cbm_pkg.
module i2cbm_front import i2cbm_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [IN_WIDTH-1:0]   i_data,
    input  logic [2:0]            i_user,
    output logic                  o_item_valid,
    output t_item                 o_item,
    input  logic                  i_item_pop
);

    t_item       r_q [2];
    logic        r_wr_ptr;
    logic        r_rd_ptr;
    logic [1:0]  r_count;
    logic        push;
    logic        pop;
    t_item       item;

    always_comb begin
        item.op     = t_op'(i_user);
        item.is_cmd = (t_op'(i_user) != OP_TICK);
        item.data   = i_data[7:0];
        item.sda    = i_data[8];
    end

    assign o_ready      = (r_count != 2'd2);
    assign push         = i_valid && o_ready;
    assign o_item_valid = (r_count != 2'd0);
    assign pop          = i_item_pop && o_item_valid;
    assign o_item       = r_q[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

### design/i2cbm_engine.sv
// Back end of the I2C bit-level master: phase sequencer, shift register,
// phase_ticks register and the output word register. Uses i2cbm_pkg.
module i2cbm_engine import i2cbm_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [7:0]            i_cfg_wdata,
    input  logic                  i_item_valid,
    input  t_item                 i_item,
    output logic                  o_item_pop,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [OUT_WIDTH-1:0]  o_data
);

    logic [7:0]           r_phase_ticks;
    t_op                  r_op,    n_op;
    logic [4:0]           r_phase, n_phase;
    logic [7:0]           r_tick,  n_tick;
    logic [7:0]           r_sr,    n_sr;
    t_lines               r_lines, n_lines;
    logic                 r_ack,   n_ack;
    logic                 r_out_valid;
    logic [OUT_WIDTH-1:0] r_out_data, n_out_data;
    logic [7:0]           limit;
    logic [7:0]           tick_inc;
    logic [4:0]           phase_inc;
    logic                 done;
    logic                 rejected;
    logic                 pop;

    assign pop        = i_item_valid && (!r_out_valid || i_ready);
    assign o_item_pop = pop;
    assign limit      = (r_phase_ticks == 8'd0) ? 8'd1 : r_phase_ticks;
    assign tick_inc   = r_tick + 8'd1;
    assign phase_inc  = r_phase + 5'd1;

    always_comb begin
        n_op     = r_op;
        n_phase  = r_phase;
        n_tick   = r_tick;
        n_sr     = r_sr;
        n_lines  = r_lines;
        n_ack    = r_ack;
        done     = 1'b0;
        rejected = 1'b0;
        if (i_item.is_cmd) begin
            if (r_op != OP_TICK) begin
                rejected = 1'b1;
            end else begin
                n_op    = i_item.op;
                n_phase = 5'd0;
                n_tick  = 8'd0;
                if (i_item.op == OP_WRITE) begin
                    n_sr = i_item.data;
                end else if (i_item.op == OP_READ) begin
                    n_sr = 8'd0;
                end
                n_lines = f_enter(i_item.op, 5'd0, n_sr[7], r_lines);
            end
        end else if (r_op != OP_TICK) begin
            if (tick_inc >= limit) begin
                n_tick = 8'd0;
                if (r_op == OP_WRITE && r_phase < 5'd16 && r_phase[0]) begin
                    n_sr = {r_sr[6:0], 1'b0};
                end else if (r_op == OP_READ && r_phase < 5'd16 && r_phase[0]) begin
                    n_sr = {r_sr[6:0], i_item.sda};
                end else if (r_op == OP_RACK && r_phase == 5'd1) begin
                    n_ack = !i_item.sda;
                end
                if (phase_inc >= f_phase_count(r_op)) begin
                    n_op    = OP_TICK;
                    n_phase = 5'd0;
                    done    = 1'b1;
                end else begin
                    n_phase = phase_inc;
                    n_lines = f_enter(r_op, phase_inc, n_sr[7], r_lines);
                end
            end else begin
                n_tick = tick_inc;
            end
        end
        n_out_data = {1'b0, rejected, n_ack, n_sr, done, (n_op != OP_TICK),
                      n_lines.drv, n_lines.sda, n_lines.scl};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_ticks <= 8'd1;
            r_op          <= OP_TICK;
            r_phase       <= 5'd0;
            r_tick        <= 8'd0;
            r_sr          <= 8'd0;
            r_lines       <= '{scl: 1'b0, sda: 1'b1, drv: 1'b1};
            r_ack         <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_phase_ticks <= i_cfg_wdata;
            end
            if (pop) begin
                r_op    <= n_op;
                r_phase <= n_phase;
                r_tick  <= n_tick;
                r_sr    <= n_sr;
                r_lines <= n_lines;
                r_ack   <= n_ack;
            end
            if (pop) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;

endmodule

### design/i2c_bit_level_master.sv
// Top level of the I2C bit-level master: front queue and phase engine.
// Depends on i2cbm_pkg, i2cbm_front and i2cbm_engine.
//
//   channel   dir   handshake                       payload
//   s_axis    in    s_axis_tvalid / s_axis_tready   tuser command, tdata data + sda_in
//   m_axis    out   m_axis_tvalid / m_axis_tready   tdata line levels and status
//   cfg       in    i_cfg_we                        i_cfg_wdata phase_ticks
//
// One word per clock sustained while m_axis is not stalled; an accepted word passes
// through the queue register, then the output register, before it shows on m_axis.
// With m_axis stalled the queue takes two more words, then s_axis_tready drops.
// Reset is synchronous; phase_ticks resets to 1 and the lines to SCL low, SDA high.
module i2c_bit_level_master import i2cbm_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [7:0]            i_cfg_wdata,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [7:0] data, [8] sda_in, [15:9] zero
    input  logic [IN_WIDTH-1:0]   s_axis_tdata,
    // [2:0] command
    input  logic [2:0]            s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [0] scl, [1] sda_out, [2] sda_drive, [3] busy_res, [4] op_done,
    // [12:5] read_byte, [13] ack_seen, [14] command_rejected, [15] zero
    output logic [OUT_WIDTH-1:0]  m_axis_tdata
);

    logic  item_valid;
    t_item item;
    logic  item_pop;

    i2cbm_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_data       (s_axis_tdata),
        .i_user       (s_axis_tuser),
        .o_item_valid (item_valid),
        .o_item       (item),
        .i_item_pop   (item_pop)
    );

    i2cbm_engine u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_item_valid (item_valid),
        .i_item       (item),
        .o_item_pop   (item_pop),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_data       (m_axis_tdata)
    );

endmodule

### design/i2cbm_checker.sv
// Port-level checks for the I2C bit-level master, bound to the top level.
// Depends on i2cbm_pkg and i2c_bit_level_master.
module i2cbm_checker import i2cbm_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [OUT_WIDTH-1:0] m_axis_tdata
);

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled word changed");

    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[4] && m_axis_tdata[3]))
        else $error("done while busy");

    a_reject_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[14] |-> m_axis_tdata[3] && !m_axis_tdata[4])
        else $error("reject while idle");

    a_release_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[2] |-> m_axis_tdata[1])
        else $error("sda low while released");

endmodule

bind i2c_bit_level_master i2cbm_checker u_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

### test/i2c_bit_level_master_chk.sv
`timescale 1ns / 1ps
// Scoreboard for the I2C bit-level master: mirrors the phase engine for every
// accepted input word and checks each output word. Depends on i2cbm_pkg.
module i2c_bit_level_master_chk import i2cbm_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [15:0] i_in_data,
    input  logic [2:0]  i_in_user,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [15:0] i_out_data,
    output int          o_mismatches,
    output int          o_pending,
    output int          o_checked,
    output int          o_finished_ops,
    output int          o_refused
);

    // output word layout, msb first
    typedef struct packed {
        logic       pad;
        logic       refused;
        logic       ack;
        logic [7:0] rbyte;
        logic       done;
        logic       busy;
        logic       drv;
        logic       sda;
        logic       scl;
    } t_status;

    t_status    expected_q[$];
    t_op        eng_op;
    logic [4:0] eng_phase;
    logic [7:0] eng_shift;
    logic [7:0] eng_ticks;
    logic [7:0] tick_limit_q;
    logic       line_scl;
    logic       line_sda;
    logic       line_drv;
    logic       ack_flag;
    int         fails;
    int         checked;
    int         finished_ops;
    int         refused;

    // line levels on entry to the current phase
    function automatic void set_lines();
        case (eng_op)
            OP_START: begin
                case (eng_phase[1:0])
                    2'd0:    {line_scl, line_sda} = 2'b01;
                    2'd1:    {line_scl, line_sda} = 2'b11;
                    2'd2:    {line_scl, line_sda} = 2'b10;
                    default: {line_scl, line_sda} = 2'b00;
                endcase
                line_drv = 1'b1;
            end
            OP_STOP: begin
                if (eng_phase == 5'd0)
                    {line_scl, line_sda} = 2'b00;
                else if (eng_phase == 5'd1)
                    {line_scl, line_sda} = 2'b10;
                else
                    {line_scl, line_sda} = 2'b11;
                line_drv = 1'b1;
            end
            OP_WRITE: begin
                if (eng_phase < 5'd16) begin
                    line_scl = eng_phase[0];
                    line_sda = eng_shift[7];
                end else begin
                    line_scl = 1'b0;
                end
                line_drv = 1'b1;
            end
            OP_READ: begin
                line_scl = (eng_phase < 5'd16) ? eng_phase[0] : 1'b0;
                line_sda = 1'b1;
                line_drv = 1'b0;
            end
            OP_ACK, OP_NACK: begin
                line_scl = (eng_phase == 5'd1);
                line_sda = (eng_op == OP_NACK);
                line_drv = 1'b1;
            end
            OP_RACK: begin
                line_scl = (eng_phase == 5'd1);
                line_sda = 1'b1;
                line_drv = 1'b0;
            end
            default: ;
        endcase
    endfunction

    function automatic t_status step_engine(input t_op cmd, input logic [7:0] data,
                                            input logic sda_in);
        t_status    r;
        logic [7:0] limit;
        logic [4:0] last_phase;
        r = '0;
        limit = (tick_limit_q == 8'd0) ? 8'd1 : tick_limit_q;
        if (cmd != OP_TICK) begin
            if (eng_op != OP_TICK) begin
                r.refused = 1'b1;
            end else begin
                eng_op    = cmd;
                eng_phase = '0;
                eng_ticks = '0;
                if (cmd == OP_WRITE)
                    eng_shift = data;
                else if (cmd == OP_READ)
                    eng_shift = '0;
                set_lines();
            end
        end else if (eng_op != OP_TICK) begin
            eng_ticks = eng_ticks + 8'd1;
            if (eng_ticks >= limit) begin
                eng_ticks = '0;
                // bit shifts happen at the end of each high phase
                if (eng_phase < 5'd16 && eng_phase[0]) begin
                    if (eng_op == OP_WRITE)
                        eng_shift = eng_shift << 1;
                    else if (eng_op == OP_READ)
                        eng_shift = {eng_shift[6:0], sda_in};
                end
                if (eng_op == OP_RACK && eng_phase == 5'd1)
                    ack_flag = ~sda_in;
                case (eng_op)
                    OP_START:          last_phase = 5'd3;
                    OP_WRITE, OP_READ: last_phase = 5'd16;
                    default:           last_phase = 5'd2;
                endcase
                if (eng_phase == last_phase) begin
                    eng_op    = OP_TICK;
                    eng_phase = '0;
                    r.done    = 1'b1;
                end else begin
                    eng_phase = eng_phase + 5'd1;
                    set_lines();
                end
            end
        end
        r.scl   = line_scl;
        r.sda   = line_sda;
        r.drv   = line_drv;
        r.busy  = (eng_op != OP_TICK);
        r.rbyte = eng_shift;
        r.ack   = ack_flag;
        return r;
    endfunction

    function automatic string show(input t_status s);
        return $sformatf("scl=%b sda=%b drv=%b busy=%b done=%b byte=%02h ack=%b refused=%b pad=%b",
                         s.scl, s.sda, s.drv, s.busy, s.done, s.rbyte, s.ack, s.refused,
                         s.pad);
    endfunction

    initial begin
        fails = 0;
        checked = 0;
        finished_ops = 0;
        refused = 0;
    end

    always @(posedge i_clk) begin
        t_status got;
        t_status want;
        if (!i_rst_n) begin
            eng_op       = OP_TICK;
            eng_phase    = '0;
            eng_shift    = '0;
            eng_ticks    = '0;
            tick_limit_q = 8'd1;
            line_scl     = 1'b0;
            line_sda     = 1'b1;
            line_drv     = 1'b1;
            ack_flag     = 1'b0;
            expected_q.delete();
        end else begin
            if (i_cfg_we)
                tick_limit_q = i_cfg_wdata;
            if (i_in_valid && i_in_ready) begin
                want = step_engine(t_op'(i_in_user), i_in_data[7:0], i_in_data[8]);
                if (want.done)
                    finished_ops++;
                if (want.refused)
                    refused++;
                expected_q.push_back(want);
            end
            if (i_out_valid && i_out_ready) begin
                got = t_status'(i_out_data);
                if (expected_q.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("result word with nothing outstanding: %s", show(got));
                end else begin
                    want = expected_q.pop_front();
                    checked++;
                    if (got.scl !== want.scl || got.sda !== want.sda ||
                        got.drv !== want.drv || got.busy !== want.busy ||
                        got.done !== want.done || got.rbyte !== want.rbyte ||
                        got.ack !== want.ack || got.refused !== want.refused ||
                        got.pad !== want.pad) begin
                        fails++;
                        if (fails <= 10)
                            $display("mismatch on result word %0d\n  expected %s\n  actual   %s",
                                     checked, show(want), show(got));
                    end
                end
            end
        end
        o_pending      <= expected_q.size();
        o_mismatches   <= fails;
        o_checked      <= checked;
        o_finished_ops <= finished_ops;
        o_refused      <= refused;
    end

endmodule

### test/i2c_bit_level_master_tb.sv
`timescale 1ns / 1ps
// Testbench top for the I2C bit-level master: clock, reset, phase length writes,
// bus command stimulus and output back-pressure, plus the verdict.
// Depends on i2cbm_pkg, i2c_bit_level_master and i2c_bit_level_master_chk.
module i2c_bit_level_master_tb;
    import i2cbm_pkg::*;

    localparam int WORD_TARGET = 2000;
    localparam int STALL_LIMIT = 3000;
    localparam int LONG_HOLD   = 250;
    localparam int SDA_RANDOM  = 2;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [7:0]  i_cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;
    logic [2:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;

    int          mismatches;
    int          pending;
    int          checked;
    int          finished_ops;
    int          refused;
    int          words_sent = 0;
    int          ticks_owed = 0;
    int          hold_requests = 0;
    int          settings_used = 0;
    int          idle_cycles = 0;
    logic [7:0]  phase_len = 8'd1;
    bit          tx_steady = 1'b0;
    bit          rx_steady = 1'b0;

    i2c_bit_level_master dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    i2c_bit_level_master_chk chk (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (s_axis_tvalid),
        .i_in_ready     (s_axis_tready),
        .i_in_data      (s_axis_tdata),
        .i_in_user      (s_axis_tuser),
        .i_out_valid    (m_axis_tvalid),
        .i_out_ready    (m_axis_tready),
        .i_out_data     (m_axis_tdata),
        .o_mismatches   (mismatches),
        .o_pending      (pending),
        .o_checked      (checked),
        .o_finished_ops (finished_ops),
        .o_refused      (refused)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(0, 7);
        if (r == 0)
            return 8'h00;
        else if (r == 1)
            return 8'hFF;
        else
            return 8'($urandom);
    endfunction

    task automatic send_word(input t_op cmd, input logic [7:0] data, input logic sda);
        bit taken;
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {7'd0, sda, data};
        do begin
            @(negedge i_clk);
            taken = s_axis_tready;
            @(posedge i_clk);
        end while (!taken);
        words_sent++;
        gap = tx_steady ? 0 : pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic tick(input int sda_mode);
        send_word(OP_TICK, 8'($urandom),
                  (sda_mode == SDA_RANDOM) ? 1'($urandom) : 1'(sda_mode));
        if (ticks_owed > 0)
            ticks_owed--;
    endtask

    // a command given while the engine is busy is refused and owes nothing
    task automatic issue(input t_op cmd, input logic [7:0] data);
        if (ticks_owed == 0) begin
            case (cmd)
                OP_START:          ticks_owed = 4 * phase_len;
                OP_WRITE, OP_READ: ticks_owed = 17 * phase_len;
                default:           ticks_owed = 3 * phase_len;
            endcase
        end
        send_word(cmd, data, 1'($urandom));
    endtask

    task automatic finish_op(input int sda_mode);
        while (ticks_owed > 0) begin
            if ($urandom_range(0, 99) < 4)
                send_word(t_op'(3'($urandom_range(1, 7))), 8'($urandom), 1'($urandom));
            else
                tick(sda_mode);
        end
        if ($urandom_range(0, 99) < 5)
            tick(SDA_RANDOM);
    endtask

    task automatic do_op(input t_op cmd, input logic [7:0] data);
        issue(cmd, data);
        finish_op(SDA_RANDOM);
    endtask

    task automatic run_transfer();
        int n;
        if ($urandom_range(0, 9) == 0) begin
            // loose command soup
            repeat ($urandom_range(1, 4))
                do_op(t_op'(3'($urandom_range(1, 7))), pick_byte());
        end else begin
            do_op(OP_START, 8'($urandom));
            do_op(OP_WRITE, pick_byte());
            do_op(OP_RACK, 8'($urandom));
            n = $urandom_range(0, 3);
            repeat (n) begin
                if ($urandom_range(0, 1)) begin
                    do_op(OP_WRITE, pick_byte());
                    do_op(OP_RACK, 8'($urandom));
                end else begin
                    do_op(OP_READ, 8'($urandom));
                    do_op($urandom_range(0, 1) ? OP_ACK : OP_NACK, 8'($urandom));
                end
            end
            if ($urandom_range(0, 4) != 0)
                do_op(OP_STOP, 8'($urandom));
        end
    endtask

    task automatic quiesce();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic load_ticks(input logic [7:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        phase_len = (v == 8'd0) ? 8'd1 : v;
        settings_used++;
    endtask

    initial begin
        int seg;
        int seg_end;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = 8'd0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // ticks while idle, refused command mid-start, each short operation
        send_word(OP_TICK, 8'hFF, 1'b1);
        send_word(OP_TICK, 8'h00, 1'b0);
        issue(OP_START, 8'h00);
        send_word(OP_WRITE, 8'hFF, 1'b1);
        finish_op(SDA_RANDOM);
        do_op(OP_ACK, 8'h00);
        do_op(OP_NACK, 8'hFF);
        issue(OP_RACK, 8'h00);
        finish_op(0);
        issue(OP_RACK, 8'h00);
        finish_op(1);
        do_op(OP_STOP, 8'h00);

        for (seg = 0; words_sent < WORD_TARGET; seg++) begin
            quiesce();
            tx_steady = (seg % 4 == 1);
            rx_steady = tx_steady;
            case (seg)
                0: begin
                    // output held off while the input keeps coming
                    load_ticks(8'd1);
                    tx_steady = 1'b1;
                    hold_requests++;
                end
                1: load_ticks(8'd0);
                2: begin
                    // longest phase, then shortened part way through it
                    load_ticks(8'd255);
                    issue(OP_START, 8'($urandom));
                    repeat (10) tick(SDA_RANDOM);
                    quiesce();
                    load_ticks(8'd1);
                    ticks_owed = 4;
                    finish_op(SDA_RANDOM);
                end
                3: load_ticks(8'd3);
                default: load_ticks(8'($urandom_range(1, 5)));
            endcase
            seg_end = words_sent + 300;
            if (seg_end > WORD_TARGET)
                seg_end = WORD_TARGET;
            while (words_sent < seg_end)
                run_transfer();
        end

        quiesce();
        repeat (10) @(posedge i_clk);
        $display("Checked %0d result words: %0d bus operations completed, %0d commands refused.",
                 checked, finished_ops, refused);
        $display("Phase length written %0d times (0, 1, 3 and 255 among them), one long output stall.",
                 settings_used);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial begin
        int holds_done;
        int gap;
        holds_done = 0;
        m_axis_tready = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_requests != holds_done) begin
                holds_done++;
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else if (rx_steady) begin
                m_axis_tready <= 1'b1;
                @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
                gap = pick_gap();
                if (gap > 0) begin
                    m_axis_tready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
        end
    end

    // no word moving on either channel for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

endmodule

### files.f
design/i2cbm_pkg.sv
design/i2cbm_front.sv
design/i2cbm_engine.sv
design/i2c_bit_level_master.sv
design/i2cbm_checker.sv
test/i2c_bit_level_master_chk.sv
test/i2c_bit_level_master_tb.sv
